@@ design/adaptive_stream_credit_window_assert.svh @@
// Assertion macros used by the checker of the credit window block.
// Depends on nothing; included by the checker file.
`ifndef ADAPTIVE_STREAM_CREDIT_WINDOW_ASSERT_SVH
`define ADAPTIVE_STREAM_CREDIT_WINDOW_ASSERT_SVH

// Property checked at every rising edge outside reset.
`define ASCW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ascw_pkg.sv @@
// Package of the credit window block: operation and status codes,
// register indexes and stream field widths. Depends on nothing.
`timescale 1ns / 1ps

package ascw_pkg;

	localparam int LENGTH_W   = 32;
	localparam int CONSUMED_W = 48;
	localparam int WINDOW_W   = 48;
	localparam int MAXWIN_W   = 32;
	localparam int MINWIN_W   = 32;
	localparam int LIMIT_W    = 48;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_PAD_W   = OUT_TDATA_W - WINDOW_W - 2;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_ADDR_W-1:0] REG_MAX_WINDOW   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_WINDOW   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SHARED_LIMIT = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE    = 2'd0,
		OP_FEEDBACK = 2'd1,
		OP_OPEN     = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED   = 3'd0,
		ST_FULL       = 3'd1,
		ST_WR_FAILED  = 3'd2,
		ST_FB_APPLIED = 3'd3,
		ST_FB_IGNORED = 3'd4,
		ST_OPENED     = 3'd5
	} status_t;

endpackage

@@ design/adaptive_stream_credit_window.sv @@
// Sender side of a byte-credit flow-control window with shared-link adaptation.
// Depends on ascw_pkg.
`timescale 1ns / 1ps

// Usage
//   Requests enter on the s_ channel: s_tuser carries the operation (write, peer
//   feedback, open), s_tdata the length, the consumed total and the downstream
//   write outcome. Each request gives exactly one result on the m_ channel:
//   status on m_tuser, window, full flag and wake flag on m_tdata.
//   The three registers are written on the cfg_ port while no request is in
//   flight; index 0 is the maximum window, 1 the minimum, 2 the shared limit.
// Timing
//   A request is held in an input register, evaluated against the window state
//   and written to the output register, which drives its result. One request
//   is taken every cycle unless the receiver stalls the result: the state
//   update closes within the single evaluation stage.
// Reset and stalls
//   Reset clears the registers, counters, window and both stages. When the
//   receiver holds m_tready low, the result stays put, the input register still
//   takes one request and s_tready then falls until the result leaves.
module adaptive_stream_credit_window
	import ascw_pkg::*;
#(
	parameter int COUNT_BITS = 48
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// [31:0] length, [79:32] consumed_total, [80] write_ok, rest zero
	input  logic [IN_TDATA_W-1:0]   s_tdata,
	// [1:0] op
	input  logic [1:0]              s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// [47:0] window, [48] is_full, [49] became_writable, rest zero
	output logic [OUT_TDATA_W-1:0]  m_tdata,
	// [2:0] status
	output logic [2:0]              m_tuser,
	input  logic                    cfg_wen,
	input  logic [CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int CW = COUNT_BITS;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? {CW{1'b1}} : s[CW-1:0];
	endfunction

	function automatic logic full_chk(input logic [CW-1:0] prod, input logic [CW-1:0] cons,
			input logic [CW-1:0] win);
		logic [CW-1:0] diff;
		diff = prod - cons;
		return (win != '0) && (prod >= cons) && (diff >= win);
	endfunction

	// Configuration registers.
	logic [MAXWIN_W-1:0] max_window_q;
	logic [MINWIN_W-1:0] min_window_q;
	logic [LIMIT_W-1:0]  shared_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_window_q   <= '0;
			min_window_q   <= '0;
			shared_limit_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_MAX_WINDOW:   max_window_q   <= cfg_wdata[MAXWIN_W-1:0];
				REG_MIN_WINDOW:   min_window_q   <= cfg_wdata[MINWIN_W-1:0];
				REG_SHARED_LIMIT: shared_limit_q <= cfg_wdata[LIMIT_W-1:0];
				default:          ;
			endcase
		end
	end

	// Input stage.
	logic                  valid_s1;
	op_t                   op_s1;
	logic [LENGTH_W-1:0]   len_s1;
	logic [CONSUMED_W-1:0] consumed_s1;
	logic                  write_ok_s1;

	// Output stage.
	logic                  valid_s2;
	status_t               status_s2;
	logic [WINDOW_W-1:0]   window_s2;
	logic                  is_full_s2;
	logic                  wake_s2;

	logic advance;
	logic fire;

	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1       <= op_t'(s_tuser);
			len_s1      <= s_tdata[LENGTH_W-1:0];
			consumed_s1 <= s_tdata[LENGTH_W+CONSUMED_W-1:LENGTH_W];
			write_ok_s1 <= s_tdata[LENGTH_W+CONSUMED_W];
		end
	end

	// Window state. full_q always equals the full test on the current state,
	// so the write path needs no subtraction of its own.
	logic [CW-1:0] produced_q;
	logic [CW-1:0] consumed_q;
	logic [CW-1:0] window_q;
	logic [CW-1:0] link_q;
	logic          full_q;

	logic [CW-1:0]       produced_n;
	logic [CW-1:0]       consumed_n;
	logic [CW-1:0]       window_n;
	logic [CW-1:0]       link_n;
	logic                full_n;
	logic                wake_n;
	status_t             status_n;

	logic [MINWIN_W-1:0] eff_min;
	logic [CW-1:0]       open_win;
	logic [CW-1:0]       newc;
	logic [CW-1:0]       delta;
	logic [CW-1:0]       link_sub;
	logic [CW-1:0]       dbl;
	logic [CW-1:0]       dbl_cap;
	logic                shared_on;
	logic                fb_apply;
	logic                crowded;
	logic                grow;

	always_comb begin
		// A minimum above a nonzero maximum counts as no minimum.
		eff_min   = ((max_window_q != '0) && (min_window_q > max_window_q)) ? '0 : min_window_q;
		shared_on = (shared_limit_q != '0);
		open_win  = (shared_on && (eff_min != '0)) ? CW'(eff_min) : CW'(max_window_q);
		newc      = CW'(consumed_s1);
		fb_apply  = (window_q != '0) && (newc > consumed_q);
		delta     = newc - consumed_q;
		link_sub  = (link_q > delta) ? (link_q - delta) : '0;
		crowded   = 64'(link_sub) > 64'(shared_limit_q);
		grow      = full_chk(produced_q, newc, window_q) &&
			((max_window_q == '0) || (64'(window_q) < 64'(max_window_q)));
		dbl       = sat_add(window_q, window_q);
		dbl_cap   = ((max_window_q != '0) && (64'(dbl) > 64'(max_window_q))) ?
			CW'(max_window_q) : dbl;

		produced_n = produced_q;
		consumed_n = consumed_q;
		window_n   = window_q;
		link_n     = link_q;
		full_n     = full_q;
		wake_n     = 1'b0;
		status_n   = ST_FB_IGNORED;

		case (op_s1)
			OP_OPEN: begin
				produced_n = '0;
				consumed_n = '0;
				window_n   = open_win;
				full_n     = 1'b0;
				status_n   = ST_OPENED;
			end
			OP_WRITE: begin
				if (full_q) begin
					status_n = ST_FULL;
				end else if (!write_ok_s1) begin
					// A refused write leaves the count as it was.
					status_n = ST_WR_FAILED;
				end else begin
					if (window_q != '0) begin
						produced_n = sat_add(produced_q, CW'(len_s1));
					end
					if (shared_on) begin
						link_n = sat_add(link_q, CW'(len_s1));
					end
					full_n   = full_chk(produced_n, consumed_q, window_q);
					status_n = ST_ACCEPTED;
				end
			end
			OP_FEEDBACK: begin
				if (fb_apply) begin
					if (shared_on) begin
						link_n = link_sub;
						if (crowded) begin
							window_n = (eff_min != '0) ? CW'(eff_min) : (window_q >> 1);
						end else if (grow) begin
							window_n = dbl_cap;
						end
					end
					consumed_n = newc;
					full_n     = full_chk(produced_q, newc, window_n);
					wake_n     = full_q && !full_n;
					status_n   = ST_FB_APPLIED;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			produced_q <= '0;
			consumed_q <= '0;
			window_q   <= '0;
			link_q     <= '0;
			full_q     <= 1'b0;
		end else if (fire) begin
			produced_q <= produced_n;
			consumed_q <= consumed_n;
			window_q   <= window_n;
			link_q     <= link_n;
			full_q     <= full_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2  <= status_n;
			window_s2  <= WINDOW_W'(window_n);
			is_full_s2 <= full_n;
			wake_s2    <= wake_n;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, wake_s2, is_full_s2, window_s2};

endmodule

@@ design/ascw_checker.sv @@
// Port-level checker of the credit window block, bound to its top level.
// Depends on ascw_pkg and adaptive_stream_credit_window_assert.svh.
`timescale 1ns / 1ps
`include "adaptive_stream_credit_window_assert.svh"

module ascw_checker
	import ascw_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [2:0]             m_tuser
);

	`ASCW_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !m_tvalid, "result shown during reset")

	`ASCW_ASSERT(a_result_holds, clk, arst_n,
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
		"stalled result changed")

	// A wake can only come from an applied feedback that left the sender not full.
	`ASCW_ASSERT(a_wake_reason, clk, arst_n,
		m_tvalid && m_tdata[WINDOW_W+1] |-> m_tuser == ST_FB_APPLIED && !m_tdata[WINDOW_W],
		"wake without applied feedback")

	`ASCW_ASSERT(a_full_refusal, clk, arst_n,
		m_tvalid && m_tuser == ST_FULL |-> m_tdata[WINDOW_W],
		"write refused while not full")

	`ASCW_ASSERT(a_open_not_full, clk, arst_n,
		m_tvalid && m_tuser == ST_OPENED |-> !m_tdata[WINDOW_W],
		"freshly opened stream reported full")

endmodule

bind adaptive_stream_credit_window ascw_checker u_ascw_checker (.*);

@@ test/adaptive_stream_credit_window_tb.sv @@
// Testbench of the credit window block: a directed table, then random phases
// checked against a behavioural predictor of the window. Depends on ascw_pkg.
`timescale 1ns / 1ps

module adaptive_stream_credit_window_tb;
	import ascw_pkg::*;

	localparam logic [1:0]  OP_UNKNOWN   = 2'd3;
	localparam logic [63:0] CNT_MAX      = 64'h0000_FFFF_FFFF_FFFF;
	localparam int          RANDOM_PHASES = 14;
	localparam int          PHASE_ITEMS   = 100;
	localparam int          HOLD_CYCLES   = 200;
	localparam int unsigned CYCLE_LIMIT   = 500000;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] len;
		logic [47:0] cons;
		logic        ok;
	} credit_req_t;

	typedef struct packed {
		status_t     status;
		logic [47:0] window;
		logic        is_full;
		logic        wake;
	} credit_res_t;

	typedef enum bit {ROW_REQUEST, ROW_CONFIG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		credit_req_t req;
		logic [31:0] max_w;
		logic [31:0] min_w;
		logic [47:0] limit;
		bit          typed;
		credit_res_t res;
	} stim_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b1;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic [1:0]             s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [2:0]             m_tuser;
	logic                   cfg_wen   = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// Predicted window state and the registers it sees.
	logic [63:0] cw_produced, cw_consumed, cw_window, cw_link;
	logic [63:0] cw_max, cw_min, cw_limit;

	credit_res_t pending_results[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	bit          hold_req = 1'b0;

	adaptive_stream_credit_window uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > CNT_MAX) ? CNT_MAX : s;
	endfunction

	// A minimum above a nonzero maximum counts as no minimum at all.
	function automatic logic [63:0] eff_min();
		return (cw_max != 0 && cw_min > cw_max) ? 64'd0 : cw_min;
	endfunction

	function automatic bit full_at(logic [63:0] consumed);
		if (cw_window == 0 || cw_produced < consumed)
			return 1'b0;
		return (cw_produced - consumed) >= cw_window;
	endfunction

	function automatic logic [47:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	task automatic credit_predict(input credit_req_t rq, output credit_res_t res);
		logic [63:0] prior, fresh, dbl, delta;
		bit          counted, full_before, wake;
		status_t     st;
		fresh = {16'b0, rq.cons};
		st    = ST_FB_IGNORED;
		wake  = 1'b0;
		case (rq.op)
			OP_OPEN: begin
				cw_produced = 0;
				cw_consumed = 0;
				cw_window   = cw_max;
				if (cw_limit != 0 && eff_min() != 0)
					cw_window = eff_min();
				st = ST_OPENED;
			end
			OP_WRITE: begin
				prior   = cw_produced;
				counted = 1'b0;
				if (cw_window != 0 && full_at(cw_consumed)) begin
					st = ST_FULL;
				end else begin
					if (cw_window != 0) begin
						cw_produced = sat_add(cw_produced, {32'b0, rq.len});
						counted     = 1'b1;
					end
					if (!rq.ok) begin
						// Only a counted write has anything to roll back.
						if (counted)
							cw_produced = prior;
						st = ST_WR_FAILED;
					end else begin
						if (cw_limit != 0)
							cw_link = sat_add(cw_link, {32'b0, rq.len});
						st = ST_ACCEPTED;
					end
				end
			end
			OP_FEEDBACK: begin
				if (cw_window != 0 && fresh > cw_consumed) begin
					full_before = full_at(cw_consumed);
					if (cw_limit != 0) begin
						delta   = fresh - cw_consumed;
						cw_link = (cw_link > delta) ? cw_link - delta : 64'd0;
						if (cw_link > cw_limit) begin
							cw_window = (eff_min() != 0) ? eff_min() : cw_window >> 1;
						end else if (full_at(fresh) && (cw_max == 0 || cw_window < cw_max)) begin
							dbl       = sat_add(cw_window, cw_window);
							cw_window = (cw_max != 0 && dbl > cw_max) ? cw_max : dbl;
						end
					end
					cw_consumed = fresh;
					wake        = full_before && !full_at(cw_consumed);
					st          = ST_FB_APPLIED;
				end
			end
			default: ;
		endcase
		res.status  = st;
		res.window  = cw_window[47:0];
		res.is_full = full_at(cw_consumed);
		res.wake    = wake;
	endtask

	function automatic stim_row_t req_row(logic [1:0] op, logic [31:0] len,
		logic [47:0] cons, logic ok);
		stim_row_t r;
		r.kind  = ROW_REQUEST;
		r.req   = '{op: op, len: len, cons: cons, ok: ok};
		r.max_w = '0;
		r.min_w = '0;
		r.limit = '0;
		r.typed = 1'b0;
		r.res   = '0;
		return r;
	endfunction

	function automatic stim_row_t chk_row(logic [1:0] op, logic [31:0] len,
		logic [47:0] cons, logic ok, status_t st, logic [47:0] win, logic full, logic wake);
		stim_row_t r;
		r       = req_row(op, len, cons, ok);
		r.typed = 1'b1;
		r.res   = '{status: st, window: win, is_full: full, wake: wake};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [31:0] max_w, logic [31:0] min_w,
		logic [47:0] limit);
		stim_row_t r;
		r       = req_row(OP_WRITE, '0, '0, 1'b0);
		r.kind  = ROW_CONFIG;
		r.max_w = max_w;
		r.min_w = min_w;
		r.limit = limit;
		return r;
	endfunction

	// Writes all three registers once the block has drained.
	task automatic load_config(logic [31:0] max_w, logic [31:0] min_w, logic [47:0] limit);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_addr  <= REG_MAX_WINDOW;
		cfg_wdata <= {16'b0, max_w};
		@(posedge clk);
		cfg_addr  <= REG_MIN_WINDOW;
		cfg_wdata <= {16'b0, min_w};
		@(posedge clk);
		cfg_addr  <= REG_SHARED_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		cw_max   = {32'b0, max_w};
		cw_min   = {32'b0, min_w};
		cw_limit = {16'b0, limit};
	endtask

	task automatic send_request(credit_req_t rq, bit typed, credit_res_t typed_res);
		int          gap;
		credit_res_t predicted;
		gap = tx_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= rq.op;
		s_tdata  <= {{(IN_TDATA_W - 81){1'b0}}, rq.ok, rq.cons, rq.len};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		credit_predict(rq, predicted);
		pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
	endtask

	function automatic logic [31:0] draw_window_reg();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom_range(1, 4096);
			4: return $urandom_range(1, 1 << 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [47:0] draw_limit_reg();
		case ($urandom_range(0, 5))
			0: return 48'd0;
			1: return 48'hFFFF_FFFF_FFFF;
			2, 3: return $urandom_range(1, 5000);
			4: return $urandom_range(1, 1 << 24);
			default: return rand48();
		endcase
	endfunction

	// Mostly writes sized against the current window and feedback that
	// moves the consumed count forward, so the window fills and adapts.
	function automatic credit_req_t draw_request();
		credit_req_t rq;
		int unsigned pick;
		logic [63:0] span, owed, sum;
		rq.op   = OP_WRITE;
		rq.len  = $urandom;
		rq.cons = rand48();
		rq.ok   = ($urandom_range(0, 9) != 0);
		pick    = $urandom_range(0, 99);
		if (pick < 3) begin
			rq.op = OP_OPEN;
		end else if (pick < 7) begin
			rq.op = 2'($urandom_range(0, 3));
		end else if (pick < 55) begin
			if (cw_window != 0 && $urandom_range(0, 9) != 0) begin
				span   = (cw_window > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : cw_window;
				span   = span >> $urandom_range(0, 4);
				rq.len = $urandom_range(0, span[31:0]);
			end
		end else begin
			rq.op = OP_FEEDBACK;
			if (cw_window != 0 && $urandom_range(0, 9) != 0) begin
				if ($urandom_range(0, 7) == 0) begin
					rq.cons = $urandom_range(0, 1) ? cw_consumed[47:0] : cw_consumed[48:1];
				end else begin
					owed    = (cw_produced > cw_consumed) ? cw_produced - cw_consumed : 64'd0;
					span    = owed + 16;
					span    = (span > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : span;
					sum     = cw_consumed + $urandom_range(1, span[31:0]);
					rq.cons = (sum > CNT_MAX) ? CNT_MAX[47:0] : sum[47:0];
				end
			end
		end
		return rq;
	endfunction

	initial begin : run_limit
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Receiver: a random stall before each result, or one long hold on demand.
	initial begin : drain_results
		int stall;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = rx_quiet ? 0 : $urandom_range(0, 18);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		credit_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d, m_tdata %h", m_tuser, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tuser);
					mismatch_count++;
				end
				if (m_tdata[47:0] !== want.window) begin
					$error("window: expected %0d, actual %0d", want.window, m_tdata[47:0]);
					mismatch_count++;
				end
				if (m_tdata[48] !== want.is_full) begin
					$error("is_full: expected %0d, actual %0d", want.is_full, m_tdata[48]);
					mismatch_count++;
				end
				if (m_tdata[49] !== want.wake) begin
					$error("became_writable: expected %0d, actual %0d", want.wake, m_tdata[49]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t plan[$];
		logic [31:0] max_w, min_w;
		logic [47:0] limit;
		cw_produced = 0;
		cw_consumed = 0;
		cw_window   = 0;
		cw_link     = 0;
		cw_max      = 0;
		cw_min      = 0;
		cw_limit    = 0;

		// Straight after reset the window is 0, so nothing is flow controlled.
		plan.insert(plan.size(), chk_row(OP_WRITE, 32'hFFFF_FFFF, '0, 1'b1,
			ST_ACCEPTED, '0, 1'b0, 1'b0));
		plan.insert(plan.size(), chk_row(OP_FEEDBACK, '0, 48'hFFFF_FFFF_FFFF, 1'b1,
			ST_FB_IGNORED, '0, 1'b0, 1'b0));
		plan.insert(plan.size(), chk_row(OP_UNKNOWN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1,
			ST_FB_IGNORED, '0, 1'b0, 1'b0));
		plan.insert(plan.size(), chk_row(OP_OPEN, '0, '0, 1'b0,
			ST_OPENED, '0, 1'b0, 1'b0));
		plan.insert(plan.size(), chk_row(OP_WRITE, '0, '0, 1'b0,
			ST_WR_FAILED, '0, 1'b0, 1'b0));
		// Fixed window, no adaptation: fill, refuse, wake, stale and rollback.
		plan.insert(plan.size(), cfg_row(32'd1000, 32'd0, 48'd0));
		plan.insert(plan.size(), chk_row(OP_OPEN, '0, '0, 1'b0,
			ST_OPENED, 48'd1000, 1'b0, 1'b0));
		plan.insert(plan.size(), req_row(OP_WRITE, 32'd1000, '0, 1'b1));
		plan.insert(plan.size(), req_row(OP_WRITE, 32'd5, '0, 1'b1));
		plan.insert(plan.size(), req_row(OP_WRITE, 32'd5, '0, 1'b0));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'd600, 1'b1));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'd600, 1'b1));
		plan.insert(plan.size(), req_row(OP_WRITE, 32'd200, '0, 1'b0));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'hFFFF_FFFF_FFFF, 1'b1));
		// Crowded link cuts to the minimum, then the window doubles to the cap.
		plan.insert(plan.size(), cfg_row(32'd64, 32'd16, 48'd100));
		plan.insert(plan.size(), req_row(OP_OPEN, '0, '0, 1'b1));
		plan.insert(plan.size(), req_row(OP_WRITE, 32'd16, '0, 1'b1));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'd8, 1'b1));
		plan.insert(plan.size(), req_row(OP_WRITE, 32'd100, '0, 1'b1));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'd10, 1'b1));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'd20, 1'b1));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'd21, 1'b1));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'd22, 1'b1));
		// Minimum above maximum means no minimum, so crowding halves the window.
		plan.insert(plan.size(), cfg_row(32'd8, 32'd20, 48'd1));
		plan.insert(plan.size(), req_row(OP_OPEN, '0, '0, 1'b1));
		plan.insert(plan.size(), req_row(OP_WRITE, 32'd8, '0, 1'b1));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'd1, 1'b1));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'd2, 1'b1));
		// Unbounded maximum with the largest minimum and limit.
		plan.insert(plan.size(), cfg_row(32'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
		plan.insert(plan.size(), req_row(OP_OPEN, '0, '0, 1'b1));
		plan.insert(plan.size(), req_row(OP_WRITE, 32'hFFFF_FFFF, '0, 1'b1));
		plan.insert(plan.size(), req_row(OP_FEEDBACK, '0, 48'd1, 1'b1));

		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CONFIG)
				load_config(plan[i].max_w, plan[i].min_w, plan[i].limit);
			else
				send_request(plan[i].req, plan[i].typed, plan[i].res);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			max_w = draw_window_reg();
			min_w = ($urandom_range(0, 3) == 0) ? max_w >> 2 : draw_window_reg();
			limit = draw_limit_reg();
			if (phase == 0) begin
				max_w = 32'hFFFF_FFFF;
				min_w = 32'hFFFF_FFFF;
				limit = 48'hFFFF_FFFF_FFFF;
			end else if (phase == 1) begin
				max_w = 32'd0;
				min_w = 32'd0;
				limit = 48'd0;
			end
			load_config(max_w, min_w, limit);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			send_request('{op: OP_OPEN, len: '0, cons: '0, ok: 1'b1}, 1'b0, '0);
			for (int n = 1; n < PHASE_ITEMS; n++)
				send_request(draw_request(), 1'b0, '0);
		end

		// Back-pressure: the receiver holds off while requests keep coming.
		load_config(32'd4096, 32'd256, 48'd3000);
		tx_quiet = 1'b1;
		rx_quiet = 1'b0;
		hold_req = 1'b1;
		send_request('{op: OP_OPEN, len: '0, cons: '0, ok: 1'b1}, 1'b0, '0);
		for (int n = 0; n < 40; n++)
			send_request(draw_request(), 1'b0, '0);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
